// ===== design/knob_volume_level_mapper_unit_defines.svh =====
// Assertion macros shared by the RTL of the volume knob level mapper.
`ifndef KNOB_VOLUME_LEVEL_MAPPER_UNIT_DEFINES_SVH
`define KNOB_VOLUME_LEVEL_MAPPER_UNIT_DEFINES_SVH

// Checked at every rising edge of i_clk, held off while reset is low.
`define KVLM_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every rising edge of i_clk, reset included.
`define KVLM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== design/kvlm_pkg.sv =====
package kvlm_pkg;

    localparam int REG_W          = 12;
    localparam int CODE_W         = 8;
    localparam int CFG_IDX_W      = 2;
    // Divisor width of the serial divider: holds 30 * 15 parts.
    localparam int DIV_W          = 9;
    localparam int DIST_W         = 9;
    localparam int PART_PER_LEVEL = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_FS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP      = 2'd2;

    localparam logic [REG_W-1:0]  RST_INIT_FS   = 12'd3269;
    localparam logic [REG_W-1:0]  RST_THRESHOLD = 12'd5;
    localparam logic [REG_W-1:0]  RST_JUMP      = 12'd20;

    localparam logic [CODE_W-1:0] CODE_ZERO   = 8'h00;
    localparam logic [CODE_W-1:0] CODE_SILENT = 8'hF0;
    localparam logic [CODE_W-1:0] CODE_BASE   = 8'hF1;
    localparam logic [DIST_W-1:0] START_DIST  = 9'd450;

    function automatic logic [DIST_W-1:0] level_mark(input logic [3:0] idx);
        logic [DIST_W-1:0] mark;
        case (idx)
            4'd0:    mark = 9'd90;
            4'd1:    mark = 9'd180;
            4'd2:    mark = 9'd220;
            4'd3:    mark = 9'd260;
            4'd4:    mark = 9'd295;
            4'd5:    mark = 9'd330;
            4'd6:    mark = 9'd365;
            4'd7:    mark = 9'd390;
            4'd8:    mark = 9'd410;
            4'd9:    mark = 9'd415;
            4'd10:   mark = 9'd420;
            4'd11:   mark = 9'd425;
            4'd12:   mark = 9'd430;
            4'd13:   mark = 9'd435;
            default: mark = 9'd450;
        endcase
        return mark;
    endfunction

endpackage

// ===== design/kvlm_if.sv =====
interface kvlm_in_if #(parameter int SAMPLE_BITS = 12);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   is_init;

    modport source (output valid, sample, is_init, input ready);
    modport sink   (input valid, sample, is_init, output ready);
endinterface

interface kvlm_out_if;
    logic                         valid;
    logic                         ready;
    logic [kvlm_pkg::CODE_W-1:0]  volume_code;
    logic                         accepted;
    logic [kvlm_pkg::REG_W-1:0]   full_scale;

    modport source (output valid, volume_code, accepted, full_scale, input ready);
    modport sink   (input valid, volume_code, accepted, full_scale, output ready);
endinterface

interface kvlm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [kvlm_pkg::CFG_IDX_W-1:0] index;
    logic [kvlm_pkg::REG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/knob_volume_level_mapper_unit.sv =====
// Volume knob level mapper.
// i_in carries one knob ADC item (sample, is_init); o_out returns one item per
// input item (volume_code, accepted, full_scale). i_cfg writes the registers
// initial_full_scale (index 0, also reloads the tracked maximum),
// change_threshold (1) and max_jump (2); it is always ready. The user must
// write it only while no item is in flight; the block does not enforce this.
// Other indexes are ignored. Items that need a new level run two restoring
// divisions through one bit-serial divider, each giving a quotient of
// DW = max(13, SAMPLE_BITS + 2) bits, and then a nearest-mark search that tests
// one table entry per cycle. Input ready stays low until the result is loaded
// into the output register, so no new item is taken while one is in flight.
// Items that keep, silence or zero the level go straight to the done state.
// A finished result sits in the output register while the next item is
// accepted; if the receiver stalls, the following result waits in the done
// state and input ready drops until the output register frees up.
// Reset (i_rst_n low at a clock edge) loads the register defaults, a tracked
// maximum of 3269, a last sample of 0, the silent code 0xF0, and empties the
// output register.
`include "knob_volume_level_mapper_unit_defines.svh"

module knob_volume_level_mapper_unit #(
    parameter int LEVEL_COUNT = 15,
    parameter int SAMPLE_BITS = 12
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    kvlm_in_if.sink      i_in,
    kvlm_out_if.source   o_out,
    kvlm_cfg_if.sink     i_cfg
);

    localparam int REG_W  = kvlm_pkg::REG_W;
    localparam int CODE_W = kvlm_pkg::CODE_W;
    localparam int DIV_W  = kvlm_pkg::DIV_W;
    localparam int DIST_W = kvlm_pkg::DIST_W;
    localparam int CW     = (SAMPLE_BITS > REG_W) ? SAMPLE_BITS : REG_W;
    localparam int DW     = (SAMPLE_BITS + 2 > 13) ? SAMPLE_BITS + 2 : 13;
    localparam int CNT_W  = $clog2(DW);
    localparam int IW     = $clog2(LEVEL_COUNT);
    localparam int PARTS  = LEVEL_COUNT * kvlm_pkg::PART_PER_LEVEL;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DIV_UNIT = 5'b00010,
        S_DIV_LVL  = 5'b00100,
        S_SEARCH   = 5'b01000,
        S_DONE     = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [REG_W-1:0]       r_init_fs, n_init_fs;
    logic [REG_W-1:0]       r_thr, n_thr;
    logic [REG_W-1:0]       r_jump, n_jump;
    logic [SAMPLE_BITS-1:0] r_last, n_last;
    logic [REG_W-1:0]       r_max, n_max;
    logic [CODE_W-1:0]      r_level, n_level;
    logic                   r_acc, n_acc;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [IW-1:0]          r_idx, n_idx;
    logic                   r_out_valid, n_out_valid;

    logic [SAMPLE_BITS-1:0] r_sample, n_sample;
    logic [DW-1:0]          r_quo, n_quo;
    logic [DIV_W-1:0]       r_rem, n_rem;
    logic [DIV_W-1:0]       r_den, n_den;
    logic [DW-1:0]          r_lvl, n_lvl;
    logic [DIST_W-1:0]      r_best, n_best;
    logic [IW-1:0]          r_bidx, n_bidx;
    logic [CODE_W-1:0]      r_out_code, n_out_code;
    logic                   r_out_acc, n_out_acc;
    logic [REG_W-1:0]       r_out_fs, n_out_fs;

    // Combinational helpers.
    logic [CW-1:0]          w_s, w_last, w_max, w_diff;
    logic                   w_in_fire, w_out_free;
    logic [DIV_W:0]         w_rem_sh;
    logic                   w_ge;
    logic [DW-1:0]          w_step_quo;
    logic [DIV_W-1:0]       w_step_rem;
    logic [DIV_W-2:0]       w_unit;
    logic [DW-1:0]          w_mark, w_dist;
    logic                   w_better;
    logic [IW-1:0]          w_fin_idx;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.volume_code = r_out_code;
    assign o_out.accepted    = r_out_acc;
    assign o_out.full_scale  = r_out_fs;

    assign w_s    = CW'(i_in.sample);
    assign w_last = CW'(r_last);
    assign w_max  = CW'(r_max);
    assign w_diff = (w_s > w_last) ? (w_s - w_last) : (w_last - w_s);

    // One restoring division step: bring down the next dividend bit.
    assign w_rem_sh   = {r_rem, r_quo[DW-1]};
    assign w_ge       = w_rem_sh >= {1'b0, r_den};
    assign w_step_rem = w_ge ? DIV_W'(w_rem_sh - {1'b0, r_den}) : DIV_W'(w_rem_sh);
    assign w_step_quo = {r_quo[DW-2:0], w_ge};
    // A rounded unit of zero counts as one.
    assign w_unit     = (w_step_quo == '0) ? (DIV_W-1)'(1) : w_step_quo[DIV_W-2:0];

    assign w_mark    = DW'(kvlm_pkg::level_mark(4'(r_idx)));
    assign w_dist    = (r_lvl > w_mark) ? (r_lvl - w_mark) : (w_mark - r_lvl);
    assign w_better  = w_dist < DW'(r_best);
    assign w_fin_idx = w_better ? r_idx : r_bidx;

    always_comb begin
        n_state     = r_state;
        n_init_fs   = r_init_fs;
        n_thr       = r_thr;
        n_jump      = r_jump;
        n_last      = r_last;
        n_max       = r_max;
        n_level     = r_level;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_sample    = r_sample;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_den       = r_den;
        n_lvl       = r_lvl;
        n_best      = r_best;
        n_bidx      = r_bidx;
        n_out_code  = r_out_code;
        n_out_acc   = r_out_acc;
        n_out_fs    = r_out_fs;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_sample = i_in.sample;
                    n_state  = S_DONE;
                    n_acc    = 1'b0;
                    if (i_in.is_init) begin
                        if (w_s > w_max) begin
                            n_max = w_s[REG_W-1:0];
                        end
                        n_last = i_in.sample;
                        n_acc  = 1'b1;
                        if (w_s == '0) begin
                            n_level = kvlm_pkg::CODE_ZERO;
                        end else begin
                            n_state = S_DIV_UNIT;
                        end
                    end else if (w_s == '0) begin
                        n_level = kvlm_pkg::CODE_SILENT;
                    end else if (w_diff >= CW'(r_thr)) begin
                        if (w_s > w_max && (w_s - w_max) > CW'(r_jump) &&
                            i_in.sample != '1) begin
                            n_max = w_s[REG_W-1:0];
                        end
                        n_last  = i_in.sample;
                        n_acc   = 1'b1;
                        n_state = S_DIV_UNIT;
                    end
                    // The divider is loaded with the rounded unit division.
                    n_quo = DW'(n_max) + DW'(PARTS / 2);
                    n_rem = '0;
                    n_den = DIV_W'(PARTS);
                    n_cnt = '0;
                end
            end
            S_DIV_UNIT: begin
                n_quo = w_step_quo;
                n_rem = w_step_rem;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DW - 1)) begin
                    n_quo   = DW'({r_sample, 1'b0}) + DW'(w_unit);
                    n_rem   = '0;
                    n_den   = {w_unit, 1'b0};
                    n_cnt   = '0;
                    n_state = S_DIV_LVL;
                end
            end
            S_DIV_LVL: begin
                n_quo = w_step_quo;
                n_rem = w_step_rem;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DW - 1)) begin
                    n_lvl   = w_step_quo;
                    n_best  = kvlm_pkg::START_DIST;
                    n_bidx  = '0;
                    n_idx   = '0;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_better) begin
                    n_best = w_dist[DIST_W-1:0];
                    n_bidx = r_idx;
                end
                n_idx = r_idx + IW'(1);
                if (r_idx == IW'(LEVEL_COUNT - 1)) begin
                    n_level = kvlm_pkg::CODE_BASE + CODE_W'(w_fin_idx);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_code  = r_level;
                    n_out_acc   = r_acc;
                    n_out_fs    = r_max;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                kvlm_pkg::CFG_INIT_FS: begin
                    n_init_fs = i_cfg.data;
                    n_max     = i_cfg.data;
                end
                kvlm_pkg::CFG_THRESHOLD: n_thr  = i_cfg.data;
                kvlm_pkg::CFG_JUMP:      n_jump = i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_init_fs   <= kvlm_pkg::RST_INIT_FS;
            r_thr       <= kvlm_pkg::RST_THRESHOLD;
            r_jump      <= kvlm_pkg::RST_JUMP;
            r_last      <= '0;
            r_max       <= kvlm_pkg::RST_INIT_FS;
            r_level     <= kvlm_pkg::CODE_SILENT;
            r_acc       <= 1'b0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_fs   <= n_init_fs;
            r_thr       <= n_thr;
            r_jump      <= n_jump;
            r_last      <= n_last;
            r_max       <= n_max;
            r_level     <= n_level;
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample   <= n_sample;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_den      <= n_den;
        r_lvl      <= n_lvl;
        r_best     <= n_best;
        r_bidx     <= n_bidx;
        r_out_code <= n_out_code;
        r_out_acc  <= n_out_acc;
        r_out_fs   <= n_out_fs;
    end

    `KVLM_ASSERT_CLK(a_accept_leaves_idle, (w_in_fire |=> (r_state != S_IDLE)), "accepted item did not start work")
    `KVLM_ASSERT_CLK(a_rem_below_den, ((r_state == S_DIV_UNIT || r_state == S_DIV_LVL) |-> (r_rem < r_den)), "divider remainder not below divisor")
    `KVLM_ASSERT_CLK(a_best_shrinks, ((r_state == S_SEARCH) |=> (r_best <= $past(r_best))), "best distance grew during search")
    `KVLM_ASSERT_CLK(a_idx_in_range, ((r_state == S_SEARCH) |-> (r_idx <= IW'(LEVEL_COUNT - 1))), "search index beyond table")
    `KVLM_ASSERT_ALWAYS(a_out_from_done, ($rose(r_out_valid) |-> $past(r_state == S_DONE)), "result loaded outside done state")

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REG_W          = kvlm_pkg::REG_W;
    localparam int CODE_W         = kvlm_pkg::CODE_W;
    localparam int CFG_IDX_W      = kvlm_pkg::CFG_IDX_W;
    localparam int PART_PER_LEVEL = kvlm_pkg::PART_PER_LEVEL;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_FS   = kvlm_pkg::CFG_INIT_FS;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = kvlm_pkg::CFG_THRESHOLD;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP      = kvlm_pkg::CFG_JUMP;

    localparam logic [REG_W-1:0]  RST_INIT_FS   = kvlm_pkg::RST_INIT_FS;
    localparam logic [REG_W-1:0]  RST_THRESHOLD = kvlm_pkg::RST_THRESHOLD;
    localparam logic [REG_W-1:0]  RST_JUMP      = kvlm_pkg::RST_JUMP;

    localparam logic [CODE_W-1:0] CODE_ZERO   = kvlm_pkg::CODE_ZERO;
    localparam logic [CODE_W-1:0] CODE_SILENT = kvlm_pkg::CODE_SILENT;
    localparam logic [CODE_W-1:0] CODE_BASE   = kvlm_pkg::CODE_BASE;
    localparam int unsigned       START_DIST  = kvlm_pkg::START_DIST;

    localparam int          LEVELS          = 15;
    localparam int          PARTS           = LEVELS * PART_PER_LEVEL;
    localparam int unsigned LEVEL_MARKS [LEVELS] = '{
        90, 180, 220, 260, 295, 330, 365, 390, 410, 415, 420, 425, 430, 435, 450
    };
    localparam logic [CODE_W-1:0]    CODE_TOP   = CODE_BASE + 8'(LEVELS - 1);
    // Index 3 names no register; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int ITEMS_PER_PHASE = 100;
    localparam int PHASES          = 8;
    localparam int SETTLE_CYCLES   = 60;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    // initial_full_scale, change_threshold, max_jump per phase; -1 draws at random.
    localparam int PHASE_SET [PHASES][3] = '{
        '{3269, 5, 20}, '{4095, 0, 0}, '{1, 4095, 4095}, '{1, 0, 0},
        '{500, 50, 100}, '{-1, -1, -1}, '{-1, -1, -1}, '{2048, 1, 4095}
    };

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              acc;
        logic [REG_W-1:0]  fs;
    } t_level_result;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [REG_W-1:0]      value;
        logic                  is_init;
        logic                  typed;
        t_level_result         res;
    } t_row;

    localparam t_level_result NO_RES = '{CODE_ZERO, 1'b0, 12'd0};

    localparam t_row DIRECTED [23] = '{
        '{ROW_ITEM, CFG_INIT_FS,   12'd0,    1'b0, 1'b1, '{CODE_SILENT, 1'b0, RST_INIT_FS}},
        '{ROW_ITEM, CFG_INIT_FS,   12'd3,    1'b0, 1'b1, '{CODE_SILENT, 1'b0, RST_INIT_FS}},
        '{ROW_ITEM, CFG_INIT_FS,   12'd0,    1'b1, 1'b1, '{CODE_ZERO, 1'b1, RST_INIT_FS}},
        '{ROW_ITEM, CFG_INIT_FS,   12'd1400, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_INIT_FS,   12'd1404, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_INIT_FS,   12'd4095, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_INIT_FS,   12'd4095, 1'b1, 1'b1, '{CODE_TOP, 1'b1, 12'd4095}},
        '{ROW_ITEM, CFG_INIT_FS,   12'd4094, 1'b0, 1'b1, '{CODE_TOP, 1'b0, 12'd4095}},
        '{ROW_ITEM, CFG_INIT_FS,   12'd1,    1'b0, 1'b1, '{CODE_BASE, 1'b1, 12'd4095}},
        '{ROW_ITEM, CFG_INIT_FS,   12'd0,    1'b0, 1'b1, '{CODE_SILENT, 1'b0, 12'd4095}},
        '{ROW_CFG,  CFG_INIT_FS,   12'd1,    1'b0, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_THRESHOLD, 12'd0,    1'b0, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_JUMP,      12'd0,    1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_INIT_FS,   12'd1,    1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_INIT_FS,   12'd3,    1'b0, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_JUMP,      12'd4095, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_INIT_FS,   12'd2000, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_THRESHOLD, 12'd4095, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_INIT_FS,   12'd4095, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_INIT_FS,   12'd0,    1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_INIT_FS,   12'd2,    1'b1, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_UNUSED,    12'd4095, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_INIT_FS,   12'd4095, 1'b1, 1'b1, '{CODE_TOP, 1'b1, 12'd4095}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    kvlm_in_if #(.SAMPLE_BITS(12)) in_if ();
    kvlm_out_if                    out_if ();
    kvlm_cfg_if                    cfg_if ();

    knob_volume_level_mapper_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Mirror of the block's registers and state.
    logic [REG_W-1:0]  knob_thresh;
    logic [REG_W-1:0]  knob_jump;
    logic [REG_W-1:0]  knob_last;
    logic [REG_W-1:0]  knob_max;
    logic [CODE_W-1:0] knob_code;

    t_level_result expected_levels [$];
    int            fail_count   = 0;
    int unsigned   cycle_count  = 0;
    bit            src_idle_en  = 1'b1;
    bit            sink_idle_en = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    function automatic logic [CODE_W-1:0] level_code_for(logic [REG_W-1:0] s,
                                                         logic [REG_W-1:0] m);
        int unsigned unit;
        int unsigned lvl;
        int unsigned best;
        int unsigned best_i;
        int unsigned mark_gap;
        if (s == '0) begin
            return CODE_ZERO;
        end
        unit = (int'(m) + PARTS / 2) / PARTS;
        if (unit == 0) begin
            unit = 1;
        end
        lvl = (2 * int'(s) + unit) / (2 * unit);
        best = START_DIST;
        best_i = 0;
        for (int i = 0; i < LEVELS; i++) begin
            mark_gap = (lvl > LEVEL_MARKS[i]) ? lvl - LEVEL_MARKS[i] : LEVEL_MARKS[i] - lvl;
            // Only a strictly closer mark wins, so ties keep the lower index.
            if (mark_gap < best) begin
                best = mark_gap;
                best_i = i;
            end
        end
        return 8'(int'(CODE_BASE) + best_i);
    endfunction

    function automatic t_level_result knob_step(logic [REG_W-1:0] s, logic init);
        t_level_result r;
        int            diff;
        r.acc = 1'b0;
        diff = int'(s) - int'(knob_last);
        if (diff < 0) begin
            diff = -diff;
        end
        if (init) begin
            if (s > knob_max) begin
                knob_max = s;
            end
            knob_last = s;
            knob_code = level_code_for(s, knob_max);
            r.acc = 1'b1;
        end else if (s == '0) begin
            knob_code = CODE_SILENT;
        end else if (diff >= int'(knob_thresh)) begin
            if (s > knob_max && (s - knob_max) > knob_jump && s != '1) begin
                knob_max = s;
            end
            knob_code = level_code_for(s, knob_max);
            knob_last = s;
            r.acc = 1'b1;
        end
        r.code = knob_code;
        r.fs = knob_max;
        return r;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
        case (idx)
            CFG_INIT_FS:   knob_max = val;
            CFG_THRESHOLD: knob_thresh = val;
            CFG_JUMP:      knob_jump = val;
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) begin
            return $urandom_range(0, 3);
        end else if (r < 19) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 100);
    endfunction

    function automatic void check_field(string name, logic [REG_W-1:0] want,
                                        logic [REG_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_sample(input logic [REG_W-1:0] s, input logic init,
                               input logic typed, input t_level_result typed_res);
        t_level_result r;
        in_if.valid   <= 1'b1;
        in_if.sample  <= s;
        in_if.is_init <= init;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        r = knob_step(s, init);
        expected_levels.push_back(typed ? typed_res : r);
        @(negedge i_clk);
    endtask

    task automatic source_pause();
        int gap;
        gap = src_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (expected_levels.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        apply_reg(idx, val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Three in ten samples are placed near the last accepted one or near the jump
    // boundary above the maximum, so that both sides of each test are hit.
    task automatic make_sample(output logic [REG_W-1:0] s, output logic init);
        int pick;
        int span;
        int v;
        pick = $urandom_range(0, 99);
        init = 1'b0;
        if (pick < 8) begin
            v = 0;
        end else if (pick < 16) begin
            init = 1'b1;
            v = $urandom_range(0, 4095);
        end else if (pick < 36) begin
            span = (knob_thresh > 12'd4000) ? 4095 : int'(knob_thresh) + 2;
            v = int'(knob_last) + int'($urandom_range(0, 2 * span)) - span;
        end else if (pick < 46) begin
            v = int'(knob_max) + int'(knob_jump) + int'($urandom_range(0, 4)) - 2;
        end else if (pick < 50) begin
            v = 4094 + int'($urandom_range(0, 1));
        end else begin
            v = $urandom_range(1, 4095);
        end
        if (v < 0) begin
            v = 0;
        end
        if (v > 4095) begin
            v = 4095;
        end
        s = v[REG_W-1:0];
    endtask

    // Result side: random stalls on ready, checked at the rising edge.
    initial begin
        int stall_left;
        stall_left = 0;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                if (sink_idle_en && $urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_level_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_levels.size() == 0) begin
                fail_count++;
                $error("volume item arrived with none expected");
            end else begin
                want = expected_levels.pop_front();
                check_field("volume_code", REG_W'(want.code), REG_W'(out_if.volume_code));
                check_field("accepted", REG_W'(want.acc), REG_W'(out_if.accepted));
                check_field("full_scale", want.fs, out_if.full_scale);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("** knob_volume_level_mapper_unit: FAILED **");
        $finish;
    end

    initial begin
        logic [REG_W-1:0] s;
        logic             init;
        int               set_fs;
        int               set_thr;
        int               set_jmp;
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.sample  = '0;
        in_if.is_init = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = CFG_INIT_FS;
        cfg_if.data   = '0;
        knob_thresh   = RST_THRESHOLD;
        knob_jump     = RST_JUMP;
        knob_last     = '0;
        knob_max      = RST_INIT_FS;
        knob_code     = CODE_SILENT;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                drain_results();
                write_reg(DIRECTED[i].idx, DIRECTED[i].value);
            end else begin
                send_sample(DIRECTED[i].value, DIRECTED[i].is_init,
                            DIRECTED[i].typed, DIRECTED[i].res);
                source_pause();
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            // Registers change only once every result of the last phase is in.
            drain_results();
            set_fs  = PHASE_SET[ph][0] < 0 ? int'($urandom_range(1, 4095)) : PHASE_SET[ph][0];
            set_thr = PHASE_SET[ph][1] < 0 ? int'($urandom_range(0, 64)) : PHASE_SET[ph][1];
            set_jmp = PHASE_SET[ph][2] < 0 ? int'($urandom_range(0, 300)) : PHASE_SET[ph][2];
            write_reg(CFG_INIT_FS, set_fs[REG_W-1:0]);
            write_reg(CFG_THRESHOLD, set_thr[REG_W-1:0]);
            write_reg(CFG_JUMP, set_jmp[REG_W-1:0]);
            src_idle_en  = (ph % 2) == 0;
            sink_idle_en = ((ph / 2) % 2) == 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                make_sample(s, init);
                send_sample(s, init, 1'b0, NO_RES);
                source_pause();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("** knob_volume_level_mapper_unit: PASSED **");
        end else begin
            $display("** knob_volume_level_mapper_unit: FAILED **");
        end
        $finish;
    end

endmodule
